// File: rtl/msq_pkg.sv
// Shared types, constants and the segment table of the marching squares cell core.
package msq_pkg;

  localparam int FRAC_BITS = 8;
  localparam int MAX_DIM = 1024;
  localparam int COORD_W = 20;
  localparam int T_W = FRAC_BITS + 1;
  localparam int NUM_LANES = 4;
  localparam int LATENCY = FRAC_BITS + 2;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_GRID_WIDTH = 2'd1;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd2;

  localparam logic [1:0] EDGE_TOP = 2'd0;
  localparam logic [1:0] EDGE_RIGHT = 2'd1;
  localparam logic [1:0] EDGE_BOTTOM = 2'd2;
  localparam logic [1:0] EDGE_LEFT = 2'd3;

  // How a lane produces its offset.
  typedef enum logic [1:0] {
    MODE_DIV,
    MODE_ZERO,
    MODE_HALF,
    MODE_FULL
  } lane_mode_t;

  typedef struct packed {
    lane_mode_t mode;
    logic [7:0] num;
    logic [7:0] den;
  } lane_in_t;

  typedef struct packed {
    logic [3:0] case_index;
    logic signed [10:0] col;
    logic signed [10:0] row;
  } side_t;

  typedef struct packed {
    logic [1:0] count;
    logic [3:0][1:0] edges;
  } seg_t;

  // Segment table; saddles resolve as separate corners.
  function automatic seg_t seg_lookup(input logic [3:0] c);
    seg_t s;
    s.count = 2'd1;
    s.edges = '0;
    case (c)
      4'd0, 4'd15: s.count = 2'd0;
      4'd1, 4'd14: s.edges = {2'd0, 2'd0, EDGE_LEFT, EDGE_BOTTOM};
      4'd2, 4'd13: s.edges = {2'd0, 2'd0, EDGE_BOTTOM, EDGE_RIGHT};
      4'd3, 4'd12: s.edges = {2'd0, 2'd0, EDGE_LEFT, EDGE_RIGHT};
      4'd4, 4'd11: s.edges = {2'd0, 2'd0, EDGE_RIGHT, EDGE_TOP};
      4'd5: begin
        s.count = 2'd2;
        s.edges = {EDGE_LEFT, EDGE_BOTTOM, EDGE_RIGHT, EDGE_TOP};
      end
      4'd6, 4'd9: s.edges = {2'd0, 2'd0, EDGE_BOTTOM, EDGE_TOP};
      4'd7, 4'd8: s.edges = {2'd0, 2'd0, EDGE_LEFT, EDGE_TOP};
      4'd10: begin
        s.count = 2'd2;
        s.edges = {EDGE_BOTTOM, EDGE_RIGHT, EDGE_LEFT, EDGE_TOP};
      end
      default: s.count = 2'd0;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/msq_cell_if.sv
// Input channel interface carrying one grid cell item.
interface msq_cell_if;
  logic valid;
  logic ready;
  logic signed [10:0] cell_col;
  logic signed [10:0] cell_row;
  logic [7:0] alpha_tl;
  logic [7:0] alpha_tr;
  logic [7:0] alpha_br;
  logic [7:0] alpha_bl;

  modport source(output valid, cell_col, cell_row, alpha_tl, alpha_tr, alpha_br, alpha_bl,
                 input ready);
  modport sink(input valid, cell_col, cell_row, alpha_tl, alpha_tr, alpha_br, alpha_bl,
               output ready);
endinterface

// File: rtl/msq_res_if.sv
// Output channel interface carrying one segment result item.
interface msq_res_if;
  logic valid;
  logic ready;
  logic [3:0] case_index;
  logic [1:0] segment_count;
  logic signed [19:0] first_ax;
  logic signed [19:0] first_ay;
  logic signed [19:0] first_bx;
  logic signed [19:0] first_by;
  logic signed [19:0] second_ax;
  logic signed [19:0] second_ay;
  logic signed [19:0] second_bx;
  logic signed [19:0] second_by;

  modport source(output valid, case_index, segment_count, first_ax, first_ay, first_bx,
                 first_by, second_ax, second_ay, second_bx, second_by, input ready);
  modport sink(input valid, case_index, segment_count, first_ax, first_ay, first_bx,
               first_by, second_ax, second_ay, second_bx, second_by, output ready);
endinterface

// File: rtl/msq_front.sv
// Front stage: corner masking, thresholding and per-edge divider setup.
module msq_front (
  input  logic clk,
  input  logic en,
  input  logic [7:0] threshold,
  input  logic [10:0] grid_width,
  input  logic [10:0] grid_height,
  input  logic signed [10:0] col,
  input  logic signed [10:0] row,
  input  logic [3:0][7:0] alpha,
  output msq_pkg::side_t side,
  output msq_pkg::lane_in_t [msq_pkg::NUM_LANES-1:0] lanes
);

  logic signed [12:0] x0, x1, y0, y1, gw, gh;
  logic in_x0, in_x1, in_y0, in_y1;
  logic [3:0][7:0] v;
  logic [3:0] cidx;
  logic [7:0] va [msq_pkg::NUM_LANES];
  logic [7:0] vb [msq_pkg::NUM_LANES];
  msq_pkg::lane_in_t lane_next [msq_pkg::NUM_LANES];

  // Corners outside the grid read as zero.
  always_comb begin
    x0 = 13'(col);
    x1 = 13'(col) + 13'sd1;
    y0 = 13'(row);
    y1 = 13'(row) + 13'sd1;
    gw = $signed({2'b00, grid_width});
    gh = $signed({2'b00, grid_height});
    in_x0 = (x0 >= 13'sd0) && (x0 < gw);
    in_x1 = (x1 >= 13'sd0) && (x1 < gw);
    in_y0 = (y0 >= 13'sd0) && (y0 < gh);
    in_y1 = (y1 >= 13'sd0) && (y1 < gh);
    v[0] = (in_x0 && in_y0) ? alpha[0] : 8'd0;
    v[1] = (in_x1 && in_y0) ? alpha[1] : 8'd0;
    v[2] = (in_x1 && in_y1) ? alpha[2] : 8'd0;
    v[3] = (in_x0 && in_y1) ? alpha[3] : 8'd0;
    cidx = {v[0] > threshold, v[1] > threshold, v[2] > threshold, v[3] > threshold};
  end

  // Edge end corners: top, right, bottom, left.
  always_comb begin
    va[0] = v[0]; vb[0] = v[1];
    va[1] = v[1]; vb[1] = v[2];
    va[2] = v[3]; vb[2] = v[2];
    va[3] = v[0]; vb[3] = v[3];
  end

  // Sign and magnitude decisions leave only a fraction below one for the divider.
  for (genvar i = 0; i < msq_pkg::NUM_LANES; i++) begin : g_lane
    logic signed [8:0] num, dd;
    logic [8:0] an, ad;
    always_comb begin
      num = $signed({1'b0, threshold}) - $signed({1'b0, va[i]});
      dd = $signed({1'b0, vb[i]}) - $signed({1'b0, va[i]});
      an = num[8] ? 9'(-num) : 9'(num);
      ad = dd[8] ? 9'(-dd) : 9'(dd);
      lane_next[i].num = an[7:0];
      lane_next[i].den = ad[7:0];
      if (dd == 9'sd0) begin
        lane_next[i].mode = msq_pkg::MODE_HALF;
      end else if (num == 9'sd0 || (num[8] != dd[8])) begin
        lane_next[i].mode = msq_pkg::MODE_ZERO;
      end else if (an >= ad) begin
        lane_next[i].mode = msq_pkg::MODE_FULL;
      end else begin
        lane_next[i].mode = msq_pkg::MODE_DIV;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        lanes[i] <= lane_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side.case_index <= cidx;
      side.col <= col;
      side.row <= row;
    end
  end

endmodule

// File: rtl/msq_div_lane.sv
// Edge lane: pipelined restoring divider, one quotient bit per stage.
module msq_div_lane (
  input  logic clk,
  input  logic en,
  input  msq_pkg::lane_in_t lane_in,
  output logic [msq_pkg::T_W-1:0] t
);

  localparam int N = msq_pkg::FRAC_BITS;

  msq_pkg::lane_mode_t mode [N+1];
  logic [7:0] den [N+1];
  logic [7:0] rem [N+1];
  logic [N-1:0] quo [N+1];

  assign mode[0] = lane_in.mode;
  assign den[0] = lane_in.den;
  assign rem[0] = lane_in.num;
  assign quo[0] = '0;

  // Each stage shifts the remainder and trial-subtracts the divisor.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [8:0] r2;
    logic take;
    always_comb begin
      r2 = {rem[k], 1'b0};
      take = r2 >= {1'b0, den[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        mode[k+1] <= mode[k];
        den[k+1] <= den[k];
        rem[k+1] <= take ? 8'(r2 - {1'b0, den[k]}) : r2[7:0];
        quo[k+1] <= {quo[k][N-2:0], take};
      end
    end
  end

  // Final offset by lane mode.
  always_comb begin
    case (mode[N])
      msq_pkg::MODE_DIV: t = {1'b0, quo[N]};
      msq_pkg::MODE_ZERO: t = '0;
      msq_pkg::MODE_HALF: t = msq_pkg::T_W'(1 << (N - 1));
      msq_pkg::MODE_FULL: t = msq_pkg::T_W'(1 << N);
      default: t = '0;
    endcase
  end

endmodule

// File: rtl/msq_merge.sv
// Merge stage: picks the lane offsets per segment and registers the result.
module msq_merge (
  input  logic clk,
  input  logic en,
  input  msq_pkg::side_t side,
  input  logic [msq_pkg::NUM_LANES-1:0][msq_pkg::T_W-1:0] t,
  output logic [3:0] case_index,
  output logic [1:0] segment_count,
  output logic [3:0][msq_pkg::COORD_W-1:0] px,
  output logic [3:0][msq_pkg::COORD_W-1:0] py
);

  localparam int CW = msq_pkg::COORD_W;
  localparam logic [CW-1:0] ONE = CW'(1 << msq_pkg::FRAC_BITS);

  msq_pkg::seg_t seg;
  logic [CW-1:0] cx, cy;
  logic [3:0][CW-1:0] px_next, py_next;

  always_comb begin
    seg = msq_pkg::seg_lookup(side.case_index);
    cx = CW'({{(CW - 11){side.col[10]}}, side.col} << msq_pkg::FRAC_BITS);
    cy = CW'({{(CW - 11){side.row[10]}}, side.row} << msq_pkg::FRAC_BITS);
  end

  // One point per segment end; unused ends are zero.
  for (genvar p = 0; p < 4; p++) begin : g_pt
    always_comb begin
      case (seg.edges[p])
        msq_pkg::EDGE_TOP: begin
          px_next[p] = cx + CW'(t[0]);
          py_next[p] = cy;
        end
        msq_pkg::EDGE_RIGHT: begin
          px_next[p] = cx + ONE;
          py_next[p] = cy + CW'(t[1]);
        end
        msq_pkg::EDGE_BOTTOM: begin
          px_next[p] = cx + CW'(t[2]);
          py_next[p] = cy + ONE;
        end
        default: begin
          px_next[p] = cx;
          py_next[p] = cy + CW'(t[3]);
        end
      endcase
      if (seg.count <= 2'(p / 2)) begin
        px_next[p] = '0;
        py_next[p] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case_index <= side.case_index;
      segment_count <= seg.count;
      px <= px_next;
      py <= py_next;
    end
  end

endmodule

// File: rtl/marching_squares_cell_core.sv
// Top level of the marching squares cell core.
// One cell item is accepted every clock while the result side keeps up; each result passes
// through a thresholding register in front, then the four parallel edge dividers, which
// resolve one quotient bit per pipeline stage, then a segment merge register behind. A
// stall on the result side holds the whole pipeline, so the input side pauses with it.
module marching_squares_cell_core (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [1:0] wr_index,
  input  logic [10:0] wr_data,
  msq_cell_if.sink grid_cell,
  msq_res_if.source result
);

  localparam int L = msq_pkg::LATENCY;
  localparam int N = msq_pkg::FRAC_BITS;

  logic [7:0] threshold;
  logic [10:0] grid_width;
  logic [10:0] grid_height;
  logic [L-1:0] vld;
  logic en;
  msq_pkg::side_t side [N+1];
  msq_pkg::lane_in_t [msq_pkg::NUM_LANES-1:0] lanes;
  logic [msq_pkg::NUM_LANES-1:0][msq_pkg::T_W-1:0] t;
  logic [3:0][msq_pkg::COORD_W-1:0] px, py;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 8'd128;
      grid_width <= 11'(msq_pkg::MAX_DIM);
      grid_height <= 11'(msq_pkg::MAX_DIM);
    end else if (wr_en) begin
      case (wr_index)
        msq_pkg::REG_THRESHOLD: threshold <= wr_data[7:0];
        msq_pkg::REG_GRID_WIDTH: grid_width <= wr_data;
        msq_pkg::REG_GRID_HEIGHT: grid_height <= wr_data;
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the result register is free or being taken.
  assign en = !vld[L-1] || result.ready;
  assign grid_cell.ready = en;
  assign result.valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], grid_cell.valid};
    end
  end

  msq_front u_front (
    .clk(clk), .en(en), .threshold(threshold), .grid_width(grid_width),
    .grid_height(grid_height), .col(grid_cell.cell_col), .row(grid_cell.cell_row),
    .alpha({grid_cell.alpha_bl, grid_cell.alpha_br, grid_cell.alpha_tr,
            grid_cell.alpha_tl}),
    .side(side[0]), .lanes(lanes)
  );

  for (genvar i = 0; i < msq_pkg::NUM_LANES; i++) begin : g_lane
    msq_div_lane u_lane (.clk(clk), .en(en), .lane_in(lanes[i]), .t(t[i]));
  end

  // Cell case and position travel alongside the divider stages.
  for (genvar k = 0; k < N; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side[k+1] <= side[k];
      end
    end
  end

  msq_merge u_merge (
    .clk(clk), .en(en), .side(side[N]), .t(t),
    .case_index(result.case_index), .segment_count(result.segment_count),
    .px(px), .py(py)
  );

  assign result.first_ax = px[0];
  assign result.first_ay = py[0];
  assign result.first_bx = px[1];
  assign result.first_by = py[1];
  assign result.second_ax = px[2];
  assign result.second_ay = py[2];
  assign result.second_bx = px[3];
  assign result.second_by = py[3];

endmodule
